// File: hw/rtl/ump_pkg.sv
// shared types, codes and sizes for the uart master command poller
// no dependencies; every other file of the block but ump_if imports this package

package ump_pkg;

	// reply store sizing
	localparam int REPLY_DEPTH = 31;
	localparam int RUN_CAP     = (REPLY_DEPTH < 31) ? REPLY_DEPTH : 31;
	localparam int ADDR_W      = $clog2(RUN_CAP);
	localparam int CNT_W       = $clog2(RUN_CAP + 1);

	// input operations
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_TX    = 2'd0;
	localparam logic [1:0] KIND_REPLY = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;

	// done status codes
	localparam logic [2:0] STS_TIMEOUT = 3'd0;
	localparam logic [2:0] STS_ACK     = 3'd1;
	localparam logic [2:0] STS_MOTION  = 3'd2;
	localparam logic [2:0] STS_STR_OK  = 3'd3;
	localparam logic [2:0] STS_STR_TRC = 3'd4;
	localparam logic [2:0] STS_BAD     = 3'd5;

	// transaction modes
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_HEART = 2'd1;
	localparam logic [1:0] MODE_SEND  = 2'd2;
	localparam logic [1:0] MODE_REQ   = 2'd3;

	// protocol characters
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam logic [7:0] CH_2 = 8'h32;
	localparam logic [7:0] CH_4 = 8'h34;
	localparam logic [7:0] CH_6 = 8'h36;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_LR = 8'h72;

	// register reset values and indexes
	localparam logic [7:0] TIMEOUT_RST = 8'd100;
	localparam logic [7:0] TERM_RST    = 8'h0D;
	localparam logic REG_TIMEOUT = 1'b0;
	localparam logic REG_TERM    = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic commit;
		logic run_clr;
		logic emit_byte;
		logic emit_done;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic has_result;
		logic run;
		logic run_empty;
		logic run_more;
		logic out_free;
	} sts_t;

endpackage

// File: hw/rtl/ump_if.sv
// valid/ready channel interfaces for input items and result words
// no dependencies

interface ump_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] byte_value;

	modport source (output valid, output operation, output byte_value, input ready);
	modport sink (input valid, input operation, input byte_value, output ready);
endinterface

interface ump_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic       mux_select;
	logic [2:0] status;
	logic       send_payload;
	logic       last;

	modport source (output valid, output kind, output data_byte, output mux_select,
		output status, output send_payload, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input mux_select,
		input status, input send_payload, input last, output ready);
endinterface

// File: hw/rtl/ump_regs.sv
// apb configuration registers: reply timeout and string terminator
// depends on ump_pkg

module ump_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  timeout_ticks,
	output logic [7:0]  terminator_char
);
	import ump_pkg::*;

	logic [7:0] timeout_q;
	logic [7:0] term_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// register writes, word index from address bit 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			term_q    <= TERM_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_TIMEOUT: timeout_q <= pwdata[7:0];
				REG_TERM:    term_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[2])
			REG_TIMEOUT: prdata = {24'd0, timeout_q};
			REG_TERM:    prdata = {24'd0, term_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign timeout_ticks   = timeout_q;
	assign terminator_char = term_q;
endmodule

// File: hw/rtl/ump_dpath.sv
// datapath: transaction state, reply store, per-item decision logic, output register
// depends on ump_pkg; driven by ump_ctrl commands

module ump_dpath (
	input  logic          clk,
	input  logic          arst_n,
	input  ump_pkg::cmd_t cmd,
	output ump_pkg::sts_t sts,
	input  logic [7:0]    timeout_ticks,
	input  logic [7:0]    terminator_char,
	input  logic [1:0]    in_operation,
	input  logic [7:0]    in_byte_value,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    out_kind,
	output logic [7:0]    out_data_byte,
	output logic          out_mux_select,
	output logic [2:0]    out_status,
	output logic          out_send_payload,
	output logic          out_last
);
	import ump_pkg::*;

	// latched item
	logic [1:0] op_q;
	logic [7:0] byte_q;

	// transaction state
	logic [1:0]       mode_q;
	logic [7:0]       lrc_q;
	logic [7:0]       tick_q;
	logic [CNT_W-1:0] wi_q;
	logic             coll_q;
	logic             sready_q;
	logic             ovf_q;
	logic             chan_q;

	// reply store and run readout
	logic [7:0]        mem_q [RUN_CAP];
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] k_q;

	// output register
	logic       ovalid_q;
	logic [1:0] okind_q;
	logic [7:0] odata_q;
	logic       omux_q;
	logic [2:0] osts_q;
	logic       ogrant_q;
	logic       olast_q;

	// next state from the item decision
	logic [1:0]       mode_n;
	logic [7:0]       lrc_n;
	logic [7:0]       tick_n;
	logic [CNT_W-1:0] wi_n;
	logic             coll_n;
	logic             sready_n;
	logic             ovf_n;
	logic             chan_n;
	logic             mem_we;
	logic             run_req;
	logic             res_ok;
	logic [1:0]       res_kind;
	logic [7:0]       res_data;
	logic [2:0]       res_status;
	logic             res_grant;
	logic             fin;
	logic [7:0]       tick_inc;
	logic             code_ok;

	// per-item decision
	always_comb begin
		mode_n     = mode_q;
		lrc_n      = lrc_q;
		tick_n     = tick_q;
		wi_n       = wi_q;
		coll_n     = coll_q;
		sready_n   = sready_q;
		ovf_n      = ovf_q;
		chan_n     = chan_q;
		mem_we     = 1'b0;
		run_req    = 1'b0;
		res_ok     = 1'b0;
		res_kind   = KIND_DONE;
		res_data   = 8'd0;
		res_status = STS_TIMEOUT;
		res_grant  = 1'b0;
		fin        = 1'b0;
		tick_inc   = (tick_q != 8'hFF) ? tick_q + 8'd1 : tick_q;
		code_ok    = (byte_q >= CH_1) && (byte_q <= CH_6);
		case (op_q)
			OP_TICK: begin
				case (mode_q)
					MODE_HEART, MODE_SEND: begin
						tick_n = tick_inc;
						if (mode_q == MODE_HEART && lrc_q == CH_R) begin
							lrc_n      = CH_0;
							fin        = 1'b1;
							res_status = STS_ACK;
						end else if (mode_q == MODE_HEART && lrc_q == CH_LR) begin
							lrc_n      = CH_0;
							fin        = 1'b1;
							res_status = STS_MOTION;
						end else if (mode_q == MODE_SEND && lrc_q == CH_A) begin
							lrc_n      = CH_0;
							fin        = 1'b1;
							res_status = STS_ACK;
							res_grant  = 1'b1;
						end else if (tick_inc >= timeout_ticks) begin
							lrc_n      = CH_0;
							fin        = 1'b1;
							res_status = STS_TIMEOUT;
						end
					end
					MODE_REQ: begin
						if (sready_q) begin
							run_req = 1'b1;
						end else if (tick_q >= timeout_ticks) begin
							wi_n       = '0;
							coll_n     = 1'b0;
							fin        = 1'b1;
							res_status = STS_TIMEOUT;
						end else begin
							tick_n = tick_q + 8'd1;
						end
					end
					default: ;
				endcase
			end
			OP_BYTE: begin
				if (!coll_q) begin
					lrc_n = byte_q;
				end else if (byte_q == terminator_char) begin
					coll_n   = 1'b0;
					sready_n = 1'b1;
				end else if (wi_q < CNT_W'(RUN_CAP)) begin
					mem_we = 1'b1;
					wi_n   = wi_q + CNT_W'(1);
				end else begin
					ovf_n = 1'b1;
				end
			end
			OP_START: begin
				if (!code_ok) begin
					fin        = 1'b1;
					res_status = STS_BAD;
				end else begin
					chan_n   = ~byte_q[0];
					tick_n   = 8'd0;
					wi_n     = '0;
					sready_n = 1'b0;
					ovf_n    = 1'b0;
					if (byte_q <= CH_2) begin
						mode_n = MODE_HEART;
						coll_n = 1'b0;
						lrc_n  = CH_0;
					end else if (byte_q <= CH_4) begin
						mode_n = MODE_REQ;
						coll_n = 1'b1;
					end else begin
						mode_n = MODE_SEND;
						coll_n = 1'b0;
						lrc_n  = CH_0;
					end
					res_ok     = 1'b1;
					res_kind   = KIND_TX;
					res_data   = byte_q;
					res_status = STS_TIMEOUT;
				end
			end
			default: ;
		endcase
		// a finished transaction gives one done word
		if (fin) begin
			mode_n   = MODE_IDLE;
			res_ok   = 1'b1;
			res_kind = KIND_DONE;
			res_data = 8'd0;
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_operation;
			byte_q <= in_byte_value;
		end
	end

	// transaction state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			lrc_q    <= CH_0;
			tick_q   <= 8'd0;
			wi_q     <= '0;
			coll_q   <= 1'b0;
			sready_q <= 1'b0;
			ovf_q    <= 1'b0;
			chan_q   <= 1'b0;
			k_q      <= '0;
		end else begin
			if (cmd.commit) begin
				mode_q   <= mode_n;
				lrc_q    <= lrc_n;
				tick_q   <= tick_n;
				wi_q     <= wi_n;
				coll_q   <= coll_n;
				sready_q <= sready_n;
				ovf_q    <= ovf_n;
				chan_q   <= chan_n;
			end
			if (cmd.run_clr)
				k_q <= '0;
			else if (cmd.emit_byte)
				k_q <= k_q + ADDR_W'(1);
			if (cmd.emit_done) begin
				mode_q   <= MODE_IDLE;
				sready_q <= 1'b0;
				wi_q     <= '0;
			end
		end
	end

	// reply store, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (cmd.commit && mem_we)
			mem_q[wi_q[ADDR_W-1:0]] <= byte_q;
		rdata_q <= mem_q[k_q];
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if ((cmd.commit && res_ok) || cmd.emit_byte || cmd.emit_done)
			ovalid_q <= 1'b1;
		else if (out_ready)
			ovalid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.commit && res_ok) begin
			okind_q  <= res_kind;
			odata_q  <= res_data;
			omux_q   <= chan_n;
			osts_q   <= res_status;
			ogrant_q <= res_grant;
			olast_q  <= 1'b1;
		end else if (cmd.emit_byte) begin
			okind_q  <= KIND_REPLY;
			odata_q  <= rdata_q;
			omux_q   <= chan_q;
			osts_q   <= STS_TIMEOUT;
			ogrant_q <= 1'b0;
			olast_q  <= 1'b0;
		end else if (cmd.emit_done) begin
			okind_q  <= KIND_DONE;
			odata_q  <= 8'd0;
			omux_q   <= chan_q;
			osts_q   <= ovf_q ? STS_STR_TRC : STS_STR_OK;
			ogrant_q <= 1'b0;
			olast_q  <= 1'b1;
		end
	end

	// status to the controller
	assign sts.has_result = res_ok;
	assign sts.run        = run_req;
	assign sts.run_empty  = (wi_q == '0);
	assign sts.run_more   = (CNT_W'(k_q) + CNT_W'(1)) < wi_q;
	assign sts.out_free   = ~ovalid_q | out_ready;

	assign out_valid        = ovalid_q;
	assign out_kind         = okind_q;
	assign out_data_byte    = odata_q;
	assign out_mux_select   = omux_q;
	assign out_status       = osts_q;
	assign out_send_payload = ogrant_q;
	assign out_last         = olast_q;
endmodule

// File: hw/rtl/ump_ctrl.sv
// controller state machine: item intake, commit and reply run sequencing
// depends on ump_pkg; commands ump_dpath

module ump_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  ump_pkg::sts_t sts,
	output ump_pkg::cmd_t cmd
);
	import ump_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_EMIT = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_n;

	// next state and commands
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.run) begin
					cmd.run_clr = 1'b1;
					state_n     = sts.run_empty ? ST_DONE : ST_RD;
				end else if (!sts.has_result || sts.out_free) begin
					cmd.commit = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			ST_RD: begin
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_byte = 1'b1;
					state_n       = sts.run_more ? ST_RD : ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit_done = 1'b1;
					state_n       = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_n;
	end
endmodule

// File: hw/rtl/uart_master_command_poller_unit.sv
// uart master command poller: an item is taken in idle, then committed into the output
// register in exec, stalling while that register is held; no new item is taken until
// the last is done. A reply run reads each reply store byte (rd), emits it (emit), then
// the done word, stalling while the output register is held. arst_n clears control
// state and restores timeout 100 and terminator 13; the reply store is not cleared
// depends on ump_pkg, ump_if, ump_regs, ump_ctrl, ump_dpath

module uart_master_command_poller_unit (
	input  logic        clk,
	input  logic        arst_n,
	ump_in_if.sink      item,
	ump_out_if.source   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ump_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [7:0] timeout_ticks;
	logic [7:0] terminator_char;
	logic       in_ready;

	// configuration registers
	ump_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.timeout_ticks   (timeout_ticks),
		.terminator_char (terminator_char)
	);

	// controller
	ump_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign item.ready = in_ready;

	// datapath
	ump_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.timeout_ticks    (timeout_ticks),
		.terminator_char  (terminator_char),
		.in_operation     (item.operation),
		.in_byte_value    (item.byte_value),
		.out_valid        (result.valid),
		.out_ready        (result.ready),
		.out_kind         (result.kind),
		.out_data_byte    (result.data_byte),
		.out_mux_select   (result.mux_select),
		.out_status       (result.status),
		.out_send_payload (result.send_payload),
		.out_last         (result.last)
	);
endmodule
